### rtl/ptad_pkg.sv
// Shared constants, types and the arctangent table for the point-to-angle block.
`default_nettype none
package ptad_pkg;

   localparam int COORD_BITS      = 12;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int ROTATION_STEPS  = 16;

   localparam int TABLE_FRAC = 20;
   localparam int PRESHIFT   = 24;
   localparam int TBL_W      = 26;
   localparam int TBL_IDX_W  = 5;

   localparam int CENTER_W = 11;
   localparam int ANGLE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DX_W  = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;
   localparam int MAG_W = DX_W - 1;
   localparam int XY_W  = MAG_W + PRESHIFT + 3;
   localparam int ZW    = 29;
   localparam int ANG_W = (ANGLE_FRAC_BITS + 9 > ANGLE_W) ? ANGLE_FRAC_BITS + 9 : ANGLE_W;
   localparam int STEP_W = $clog2(ROTATION_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE = 2'd2;

   localparam logic [CENTER_W-1:0] CENTER_RESET = 11'd50;
   localparam logic [ANGLE_W-1:0]  MAX_RESET    = ANGLE_W'(360 * (1 << ANGLE_FRAC_BITS));
   localparam logic [ANGLE_W-1:0]  HELD_RESET   = ANGLE_W'(90 * (1 << ANGLE_FRAC_BITS));

   typedef struct packed {
      logic              load;
      logic              rotate;
      logic [STEP_W-1:0] step;
      logic              commit;
   } ptad_cmd_type;

   // arctangent of 2^-i in units of 2^-20 degree
   function automatic logic [TBL_W-1:0] atan_entry(input logic [TBL_IDX_W-1:0] idx);
      logic [TBL_W-1:0] v;
      case (idx)
         5'd0:    v = 26'd47185920;
         5'd1:    v = 26'd27855475;
         5'd2:    v = 26'd14718068;
         5'd3:    v = 26'd7471121;
         5'd4:    v = 26'd3750058;
         5'd5:    v = 26'd1876857;
         5'd6:    v = 26'd938658;
         5'd7:    v = 26'd469357;
         5'd8:    v = 26'd234682;
         5'd9:    v = 26'd117342;
         5'd10:   v = 26'd58671;
         5'd11:   v = 26'd29335;
         5'd12:   v = 26'd14668;
         5'd13:   v = 26'd7334;
         5'd14:   v = 26'd3667;
         5'd15:   v = 26'd1833;
         5'd16:   v = 26'd917;
         5'd17:   v = 26'd458;
         5'd18:   v = 26'd229;
         5'd19:   v = 26'd115;
         5'd20:   v = 26'd57;
         5'd21:   v = 26'd29;
         5'd22:   v = 26'd14;
         5'd23:   v = 26'd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/ptad_ctrl.sv
// Controller: sequences load, rotation steps and commit, and owns the result valid flag.
`default_nettype none
module ptad_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ptad_pkg::ptad_cmd_type     cmd
);
   import ptad_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ROT  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              commit;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      commit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROTATION_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.rotate = (state_ff == ST_ROT);
   assign cmd.step   = step_ff;
   assign cmd.commit = commit;

endmodule
`default_nettype wire

### rtl/ptad_dp.sv
// Datapath: config registers, CORDIC vectoring unit, quadrant fix-up, held angle and result register.
`default_nettype none
module ptad_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ptad_pkg::ptad_cmd_type                 cmd,
   input  wire logic signed [ptad_pkg::COORD_BITS-1:0] req_point_x,
   input  wire logic signed [ptad_pkg::COORD_BITS-1:0] req_point_y,
   input  wire logic                                   csr_valid,
   input  wire logic [ptad_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [ptad_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic [ptad_pkg::ANGLE_W-1:0]                rsp_angle,
   output logic                                        rsp_updated,
   output logic                                        rsp_at_center
);
   import ptad_pkg::*;

   localparam logic signed [ZW-1:0] Z_LIMIT = ZW'(90 * (1 << TABLE_FRAC));
   localparam logic [ZW-1:0]        Z_HALF  = ZW'(1 << (TABLE_FRAC - ANGLE_FRAC_BITS - 1));
   localparam int                   RND_SH  = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam logic [ANG_W-1:0] A_90   = ANG_W'(90 * (1 << ANGLE_FRAC_BITS));
   localparam logic [ANG_W-1:0] A_180  = ANG_W'(180 * (1 << ANGLE_FRAC_BITS));
   localparam logic [ANG_W-1:0] A_270  = ANG_W'(270 * (1 << ANGLE_FRAC_BITS));
   localparam logic [ANG_W-1:0] A_360  = ANG_W'(360 * (1 << ANGLE_FRAC_BITS));

   logic [CENTER_W-1:0] center_x_ff, center_y_ff;
   logic [ANGLE_W-1:0]  max_angle_ff;
   logic [ANGLE_W-1:0]  held_ff, held_in;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]   z_ff, z_in;
   logic dx_neg_ff, dy_neg_ff, dx_zero_ff, dy_zero_ff;

   logic [ANGLE_W-1:0] rsp_angle_ff;
   logic               rsp_updated_ff, rsp_at_center_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= CENTER_RESET;
         center_y_ff  <= CENTER_RESET;
         max_angle_ff <= MAX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_X:  center_x_ff  <= csr_data[CENTER_W-1:0];
            CSR_CENTER_Y:  center_y_ff  <= csr_data[CENTER_W-1:0];
            CSR_MAX_ANGLE: max_angle_ff <= csr_data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // load: offsets from the centre and their magnitudes
   logic signed [DX_W-1:0] dx, dy;
   logic [DX_W-1:0]        dx_mag, dy_mag;

   assign dx = $signed({{(DX_W-COORD_BITS){req_point_x[COORD_BITS-1]}}, req_point_x})
             - $signed({{(DX_W-CENTER_W){1'b0}}, center_x_ff});
   assign dy = $signed({{(DX_W-COORD_BITS){req_point_y[COORD_BITS-1]}}, req_point_y})
             - $signed({{(DX_W-CENTER_W){1'b0}}, center_y_ff});
   assign dx_mag = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
   assign dy_mag = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);

   // one vectoring step
   logic signed [XY_W-1:0] xs, ys;
   logic signed [ZW-1:0]   dz;
   logic                   y_pos;

   assign xs    = x_ff >>> cmd.step;
   assign ys    = y_ff >>> cmd.step;
   assign dz    = $signed({{(ZW-TBL_W){1'b0}}, atan_entry(TBL_IDX_W'(cmd.step))});
   assign y_pos = !y_ff[XY_W-1] && (y_ff != '0);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cmd.load) begin
         x_in = $signed({{(XY_W-MAG_W-PRESHIFT){1'b0}}, dx_mag[MAG_W-1:0], {PRESHIFT{1'b0}}});
         y_in = $signed({{(XY_W-MAG_W-PRESHIFT){1'b0}}, dy_mag[MAG_W-1:0], {PRESHIFT{1'b0}}});
         z_in = '0;
      end else if (cmd.rotate) begin
         if (y_pos) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + dz;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - dz;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.load) begin
         dx_neg_ff  <= dx[DX_W-1];
         dy_neg_ff  <= dy[DX_W-1];
         dx_zero_ff <= (dx == '0);
         dy_zero_ff <= (dy == '0);
      end
   end

   // clamp, round, quadrant fix-up
   logic [ZW-1:0]    z_clamp, z_round, z_shift;
   logic [ANG_W-1:0] base, ang;
   logic             at_center, take;

   always_comb begin
      if (z_ff[ZW-1]) begin
         z_clamp = '0;
      end else if (z_ff > Z_LIMIT) begin
         z_clamp = Z_LIMIT;
      end else begin
         z_clamp = z_ff;
      end
      z_round = z_clamp + Z_HALF;
      z_shift = z_round >> RND_SH;
      base    = z_shift[ANG_W-1:0];

      if (dy_zero_ff) begin
         ang = dx_neg_ff ? A_180 : A_360;
      end else if (dx_zero_ff) begin
         ang = dy_neg_ff ? A_90 : A_270;
      end else if (!dx_neg_ff && dy_neg_ff) begin
         ang = base;
      end else if (dx_neg_ff && dy_neg_ff) begin
         ang = A_180 - base;
      end else if (dx_neg_ff) begin
         ang = A_180 + base;
      end else begin
         ang = A_360 - base;
      end

      at_center = dx_zero_ff && dy_zero_ff;
      take      = !at_center && (ang <= ANG_W'(max_angle_ff));
      held_in   = take ? ang[ANGLE_W-1:0] : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_RESET;
      end else if (cmd.commit) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_angle_ff     <= held_in;
         rsp_updated_ff   <= take;
         rsp_at_center_ff <= at_center;
      end
   end

   assign rsp_angle     = rsp_angle_ff;
   assign rsp_updated   = rsp_updated_ff;
   assign rsp_at_center = rsp_at_center_ff;

endmodule
`default_nettype wire

### rtl/point_to_angle_degrees.sv
// Top level of the point-to-angle block: controller plus datapath.
`default_nettype none
// Finds the direction of a pointer position seen from the configured centre, in
// 1/128 degree, with screen y growing downward (above the centre is 90 degrees,
// the positive x axis gives 360). The first-quadrant angle comes from a CORDIC
// vectoring unit that does one shift-add rotation per clock, 16 rotations per item.
// Each item is accepted only while the block is idle: the accepting edge loads
// the operands, then the rotation steps run, then a fix-up step writes the result
// register; that write waits while a previous result is not yet taken. A new item
// is accepted in the cycle after that write, even while the previous result still
// waits on rsp_ready; a second finished result then waits for the first.
// A point at the centre, or an angle above max_angle, keeps the held angle and
// reports updated low. Configuration writes are always taken (csr_ready is high)
// and must only be issued while the block is idle.
module point_to_angle_degrees (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [ptad_pkg::COORD_BITS-1:0] req_point_x,
   input  wire logic signed [ptad_pkg::COORD_BITS-1:0] req_point_y,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [ptad_pkg::ANGLE_W-1:0]                rsp_angle,
   output logic                                        rsp_updated,
   output logic                                        rsp_at_center,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [ptad_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [ptad_pkg::CSR_DATA_W-1:0]        csr_data
);
   import ptad_pkg::*;

   ptad_cmd_type cmd;

   assign csr_ready = 1'b1;

   ptad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ptad_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_angle     (rsp_angle),
      .rsp_updated   (rsp_updated),
      .rsp_at_center (rsp_at_center)
   );

endmodule
`default_nettype wire

### rtl/ptad_checker.sv
// Port-level checker for the point-to-angle block and its bind.
`default_nettype none
module ptad_props (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [ptad_pkg::ANGLE_W-1:0] rsp_angle,
   input  wire logic                        rsp_updated,
   input  wire logic                        rsp_at_center
);
   import ptad_pkg::*;

   // one item in flight: no second accept right after the first
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted item");

   a_center_not_updated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_center |-> !rsp_updated)
      else $error("at_center result reports an update");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle)
         && $stable(rsp_updated) && $stable(rsp_at_center))
      else $error("stalled result changed");

endmodule

bind point_to_angle_degrees ptad_props u_ptad_props (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_angle     (rsp_angle),
   .rsp_updated   (rsp_updated),
   .rsp_at_center (rsp_at_center)
);
`default_nettype wire
